FILE: hw/rtl/lgr_pkg.sv
// shared constants for the life generation row block
`timescale 1ns / 1ps
`default_nettype none

package lgr_pkg;

	localparam int DATA_W     = 64;
	localparam int CFG_W      = 7;
	localparam int ROW_W_DEF  = 64;
	localparam int NBR_N      = 8;
	localparam int NBR_CNT_W  = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic [CFG_W-1:0]     ACTIVE_WIDTH_RST = 7'd10;
	localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT      = 4'd3;
	localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT    = 4'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/lgr_cell.sv
// one cell lane: neighbour count and birth/survival rule
`timescale 1ns / 1ps
`default_nettype none

module lgr_cell (
	input  wire logic [lgr_pkg::NBR_N-1:0] nbr,
	input  wire logic                      self_alive,
	output logic                           next_alive
);

	logic [lgr_pkg::NBR_CNT_W-1:0] cnt;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < lgr_pkg::NBR_N; i++) begin
			cnt = cnt + lgr_pkg::NBR_CNT_W'(nbr[i]);
		end
	end

	assign next_alive = (cnt == lgr_pkg::BIRTH_COUNT) ||
		(self_alive && (cnt == lgr_pkg::SURVIVE_COUNT));

endmodule

`default_nettype wire

FILE: hw/rtl/lgr_row.sv
// row of cell lanes with masking and any-alive merge
`timescale 1ns / 1ps
`default_nettype none

module lgr_row #(
	parameter int ROW_WIDTH = lgr_pkg::ROW_W_DEF
) (
	input  wire logic [ROW_WIDTH-1:0] up_row,
	input  wire logic [ROW_WIDTH-1:0] mid_row,
	input  wire logic [ROW_WIDTH-1:0] low_row,
	input  wire logic [ROW_WIDTH-1:0] mask,
	output logic      [ROW_WIDTH-1:0] next_row,
	output logic                      any_alive
);

	logic [ROW_WIDTH+1:0] up_x;
	logic [ROW_WIDTH+1:0] mid_x;
	logic [ROW_WIDTH+1:0] low_x;
	logic [ROW_WIDTH-1:0] lane_out;

	// dead border cells on both sides
	assign up_x  = {1'b0, up_row, 1'b0};
	assign mid_x = {1'b0, mid_row, 1'b0};
	assign low_x = {1'b0, low_row, 1'b0};

	for (genvar k = 0; k < ROW_WIDTH; k++) begin : g_lane
		lgr_cell u_cell (
			.nbr       ({up_x[k+2:k], mid_x[k+2], mid_x[k], low_x[k+2:k]}),
			.self_alive(mid_x[k+1]),
			.next_alive(lane_out[k])
		);
	end

	assign next_row  = lane_out & mask;
	assign any_alive = |next_row;

endmodule

`default_nettype wire

FILE: hw/rtl/life_generation_rows.sv
// life_generation_rows: one B3/S23 generation over a streamed, non-wrapping board
// channels: rows enter on s_axis (tdata = row cells, tlast = bottom row of
// the board) and new rows leave on m_axis (tdata = new row, tlast = final row
// of the new board, tuser = some emitted cell of this board is alive)
// cfg_wen/cfg_wdata set the active width, to be written only while the block
// idles; the block itself does not enforce this; each row is computed by
// ROW_WIDTH cell lanes side by side; the first row of a board emits nothing;
// every later row emits the new row above it; the bottom row emits two items,
// a one-row board one item; items pass through the output queue registers to
// m_axis; throughput is one input row per cycle while s_axis_tready is high;
// the extra item of the bottom row is absorbed by the four-entry output queue
// s_axis_tready stays high while the queue has room for two items, so the
// sender is held back only when a receiver stall leaves under two free slots
// reset clears held_q, the queue and alive flag and sets the active width to 10
`timescale 1ns / 1ps
`default_nettype none

module life_generation_rows #(
	parameter int ROW_WIDTH = lgr_pkg::ROW_W_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [lgr_pkg::CFG_W-1:0]  cfg_wdata,   // active_width
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire logic [lgr_pkg::DATA_W-1:0] s_axis_tdata, // row_cells
	input  wire logic                       s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic      [lgr_pkg::DATA_W-1:0] m_axis_tdata, // next_row_cells
	output logic                            m_axis_tlast,
	output logic                            m_axis_tuser  // any_alive
);

	localparam int CfgW  = lgr_pkg::CFG_W;
	localparam int DataW = lgr_pkg::DATA_W;
	localparam int PtrW  = lgr_pkg::FIFO_PTR_W;
	localparam int CntW  = lgr_pkg::FIFO_CNT_W;
	localparam int Depth = lgr_pkg::FIFO_DEPTH;

	logic [CfgW-1:0]      active_width_q;
	logic [ROW_WIDTH-1:0] mask;
	logic [ROW_WIDTH-1:0] row_in;
	logic [ROW_WIDTH-1:0] upper_q;
	logic [ROW_WIDTH-1:0] middle_q;
	logic                 held_q;
	logic                 alive_seen_q;

	logic [ROW_WIDTH-1:0] up_a;
	logic [ROW_WIDTH-1:0] mid_a;
	logic [ROW_WIDTH-1:0] low_a;
	logic [ROW_WIDTH-1:0] next_a;
	logic [ROW_WIDTH-1:0] next_b;
	logic                 any_a;
	logic                 any_b;
	logic                 alive_a;
	logic                 alive_b;

	logic                 accept;
	logic                 pop;
	logic                 push_a;
	logic                 push_b;
	logic                 last_a;

	logic [ROW_WIDTH-1:0] fifo_row_q   [Depth];
	logic                 fifo_last_q  [Depth];
	logic                 fifo_alive_q [Depth];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      wr_ptr_nx;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [CntW-1:0]      count_q;

	always_comb begin
		for (int k = 0; k < ROW_WIDTH; k++) begin
			mask[k] = active_width_q > CfgW'(k);
		end
	end

	assign row_in = s_axis_tdata[ROW_WIDTH-1:0] & mask;

	// lane group a: row above the incoming one, or a one-row board
	assign up_a  = held_q ? upper_q  : '0;
	assign mid_a = held_q ? middle_q : row_in;
	assign low_a = held_q ? row_in   : '0;

	lgr_row #(.ROW_WIDTH(ROW_WIDTH)) u_row_a (
		.up_row   (up_a),
		.mid_row  (mid_a),
		.low_row  (low_a),
		.mask     (mask),
		.next_row (next_a),
		.any_alive(any_a)
	);

	// lane group b: bottom row
	lgr_row #(.ROW_WIDTH(ROW_WIDTH)) u_row_b (
		.up_row   (middle_q),
		.mid_row  (row_in),
		.low_row  ('0),
		.mask     (mask),
		.next_row (next_b),
		.any_alive(any_b)
	);

	assign alive_a = alive_seen_q | any_a;
	assign alive_b = alive_a | any_b;

	assign accept    = s_axis_tvalid & s_axis_tready;
	assign pop       = m_axis_tvalid & m_axis_tready;
	assign push_a    = accept & (held_q | s_axis_tlast);
	assign push_b    = accept & held_q & s_axis_tlast;
	assign last_a    = s_axis_tlast & ~held_q;
	assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

	assign s_axis_tready = count_q <= CntW'(Depth - 2);
	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tdata  = DataW'(fifo_row_q[rd_ptr_q]);
	assign m_axis_tlast  = fifo_last_q[rd_ptr_q];
	assign m_axis_tuser  = fifo_alive_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q <= lgr_pkg::ACTIVE_WIDTH_RST;
			held_q         <= 1'b0;
			alive_seen_q   <= 1'b0;
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			count_q        <= '0;
		end else begin
			if (cfg_wen) begin
				active_width_q <= cfg_wdata;
			end
			if (accept) begin
				if (s_axis_tlast) begin
					held_q       <= 1'b0;
					alive_seen_q <= 1'b0;
				end else begin
					held_q <= 1'b1;
					if (held_q) begin
						alive_seen_q <= alive_a;
					end
				end
			end
			wr_ptr_q <= wr_ptr_q + PtrW'(push_a) + PtrW'(push_b);
			rd_ptr_q <= rd_ptr_q + PtrW'(pop);
			count_q  <= count_q + CntW'(push_a) + CntW'(push_b) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !s_axis_tlast) begin
			upper_q  <= held_q ? middle_q : '0;
			middle_q <= row_in;
		end
		for (int i = 0; i < Depth; i++) begin
			if (push_a && (wr_ptr_q == PtrW'(i))) begin
				fifo_row_q[i]   <= next_a;
				fifo_last_q[i]  <= last_a;
				fifo_alive_q[i] <= alive_a;
			end
			if (push_b && (wr_ptr_nx == PtrW'(i))) begin
				fifo_row_q[i]   <= next_b;
				fifo_last_q[i]  <= 1'b1;
				fifo_alive_q[i] <= alive_b;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lgr_checker.sv
// port checks for life_generation_rows and their bind
`timescale 1ns / 1ps
`default_nettype none

module lgr_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       m_axis_tvalid,
	input wire logic                       m_axis_tready,
	input wire logic [lgr_pkg::DATA_W-1:0] m_axis_tdata,
	input wire logic                       m_axis_tlast,
	input wire logic                       m_axis_tuser
);

	// output queue empties during reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output item changed while stalled");

	// a row with live cells must report the board alive
	a_alive_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata != '0) |-> m_axis_tuser)
		else $error("live row without alive flag");

	// alive flag is sticky within a board
	a_alive_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast)
			&& m_axis_tvalid |-> m_axis_tuser)
		else $error("alive flag cleared inside a board");

endmodule

bind life_generation_rows lgr_checker u_lgr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
